// File: src/bale_pkg.sv
`timescale 1ns / 1ps
// bale_pkg: shared types and codes for the bounded array list engine.
// Depends on nothing; used by every module of the block.

package bale_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMPARE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    match;
        logic signed [VAL_W-1:0] read_value;
        logic [COUNT_W-1:0]      count;
        logic                    is_empty;
        logic                    is_full;
    } rsp_t;

endpackage

// File: src/bale_store.sv
`timescale 1ns / 1ps
// bale_store: entry memory, one write port and one registered read port.
// Depends on bale_pkg for the data width and the default depth.

module bale_store #(
    parameter int DEPTH = bale_pkg::DEF_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bale_pkg::VAL_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [bale_pkg::VAL_W-1:0] rdata
);

    logic [bale_pkg::VAL_W-1:0] mem [DEPTH];
    logic [bale_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bale_ctrl.sv
`timescale 1ns / 1ps
// bale_ctrl: command checks, entry count and the shift/access sequencer.
// Depends on bale_pkg; drives the ports of bale_store.

module bale_ctrl #(
    parameter int CAPACITY = bale_pkg::DEF_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  bale_pkg::cmd_t             cmd,
    output logic                       res_valid,
    input  logic                       res_take,
    output bale_pkg::rsp_t             res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [bale_pkg::VAL_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_raddr,
    input  logic [bale_pkg::VAL_W-1:0] mem_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_INS     = 3'd2;
    localparam logic [2:0] S_INSLAST = 3'd3;
    localparam logic [2:0] S_REM     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [bale_pkg::VAL_W-1:0]    val_reg, val_next;
    logic                          cmp_reg, cmp_next;
    logic [bale_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          match_reg, match_next;
    logic [bale_pkg::VAL_W-1:0]    value_reg, value_next;

    logic [CMPW-1:0]               pos_x, cnt_x;
    logic                          full, empty;
    logic [bale_pkg::STATUS_W-1:0] live_st;
    logic [CW-1:0]                 rem_end;

    assign pos_x   = CMPW'(cmd.position);
    assign cnt_x   = CMPW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign live_st = empty ? bale_pkg::ST_EMPTY :
                     (pos_x >= cnt_x) ? bale_pkg::ST_RANGE : bale_pkg::ST_OK;
    assign rem_end = CW'(idx_reg) + CW'(2);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        cmp_next    = cmp_reg;
        status_next = status_reg;
        match_next  = match_reg;
        value_next  = value_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    status_next = bale_pkg::ST_OK;
                    match_next  = 1'b0;
                    value_next  = '0;
                    val_next    = cmd.item_value;
                    state_next  = S_DONE;
                    case (cmd.mode)
                        bale_pkg::MODE_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = bale_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = cmd.item_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bale_pkg::MODE_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                status_next = bale_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = bale_pkg::ST_FULL;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = cmd.item_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg);
                                pos_next   = AW'(cmd.position);
                                state_next = S_INS;
                            end
                        end
                        bale_pkg::MODE_REMOVE:
                        begin
                            status_next = live_st;
                            if (live_st == bale_pkg::ST_OK)
                            begin
                                if (pos_x + CMPW'(1) == cnt_x)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = AW'(cmd.position) + AW'(1);
                                    idx_next   = AW'(cmd.position);
                                    state_next = S_REM;
                                end
                            end
                        end
                        bale_pkg::MODE_REPLACE:
                        begin
                            status_next = live_st;
                            if (live_st == bale_pkg::ST_OK)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(cmd.position);
                                mem_wdata = cmd.item_value;
                            end
                        end
                        bale_pkg::MODE_COMPARE, bale_pkg::MODE_READ:
                        begin
                            status_next = live_st;
                            cmp_next    = (cmd.mode == bale_pkg::MODE_COMPARE);
                            if (live_st == bale_pkg::ST_OK)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(cmd.position);
                                state_next = S_READ;
                            end
                        end
                        bale_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                value_next = mem_rdata;
                match_next = cmp_reg && (mem_rdata == val_reg);
                state_next = S_DONE;
            end
            S_INS:
            begin
                // entry idx-1 moves up to idx
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if ((idx_reg - AW'(1)) == pos_reg)
                begin
                    state_next = S_INSLAST;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1) - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end
            S_INSLAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_REM:
            begin
                // entry idx+1 moves down to idx
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (rem_end == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(rem_end);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        cmp_reg    <= cmp_next;
        status_reg <= status_next;
        match_reg  <= match_next;
        value_reg  <= value_next;
    end

    always_comb
    begin
        res.status     = status_reg;
        res.match      = match_reg;
        res.read_value = value_reg;
        res.count      = bale_pkg::COUNT_W'(count_reg);
        res.is_empty   = empty;
        res.is_full    = full;
    end

endmodule

// File: src/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// bounded_array_list_engine: top level, output register and assertions.
// Depends on bale_pkg, bale_ctrl and bale_store.
//
// Usage:
//   Commands arrive on cmd (cmd_valid/cmd_ready), one result per command
//   leaves on rsp (rsp_valid/rsp_ready). One command is worked at a time;
//   cmd_ready is high only while the sequencer is idle.
//   Work states between command transfer and the output register:
//     append, replace, clear, status, any error, remove of the last entry: none
//     read_at, compare_at: S_READ
//     insert_at position p with count n (p < n): S_INS per moved entry, then S_INSLAST
//     remove_at position p with count n (p < n - 1): S_REM per moved entry
//   A shift moves one entry per cycle through the single memory port pair.
//   Reset clears the count and the handshakes; entry contents are not
//   cleared and no clearing pass is needed.
//   A finished result sits in the output register; the next command is
//   taken while it waits. If rsp_ready stays low, the following result
//   holds in the sequencer and cmd_ready stays low until it moves on.

module bounded_array_list_engine #(
    parameter int CAPACITY = bale_pkg::DEF_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  bale_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bale_pkg::rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                       res_valid, res_take;
    bale_pkg::rsp_t             res;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [bale_pkg::VAL_W-1:0] mem_wdata, mem_rdata;

    logic           rsp_valid_reg;
    bale_pkg::rsp_t rsp_reg;

    bale_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bale_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while a command is in work");

    a_empty_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.is_empty && rsp.is_full))
        else $error("result flags both empty and full");

    a_match_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.match) |-> (rsp.status == bale_pkg::ST_OK))
        else $error("match reported on a failed command");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != bale_pkg::ST_OK)) |-> (rsp.read_value == '0))
        else $error("nonzero read value on a failed command");

endmodule

// File: test/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps
// bounded_array_list_engine_tb: self-checking testbench for the bounded array list engine.
// Depends on bale_pkg and bounded_array_list_engine; mirrors the list in the testbench.

module bounded_array_list_engine_tb;

    localparam int CAP         = bale_pkg::DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    bale_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    bale_pkg::rsp_t rsp;

    logic signed [bale_pkg::VAL_W-1:0] mirror_entries [CAP];
    int   mirror_count = 0;
    bale_pkg::rsp_t replies_owed [$];

    int   error_count = 0;
    int   cycle_count = 0;
    bit   sender_idles = 1'b1;
    bit   receiver_idles = 1'b1;
    int   long_hold_req = 0;

    bounded_array_list_engine #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [bale_pkg::STATUS_W-1:0] live_status(input int p);
        if (mirror_count == 0)
            return bale_pkg::ST_EMPTY;
        if (p >= mirror_count)
            return bale_pkg::ST_RANGE;
        return bale_pkg::ST_OK;
    endfunction

    // Applies one command to the mirrored list and returns the reply it owes.
    function automatic bale_pkg::rsp_t apply_list_cmd(input bale_pkg::cmd_t c);
        bale_pkg::rsp_t r;
        int   p;
        int   i;
        r = '0;
        r.status = bale_pkg::ST_OK;
        p = c.position;
        case (c.mode)
            bale_pkg::MODE_APPEND:
            begin
                if (mirror_count >= CAP)
                    r.status = bale_pkg::ST_FULL;
                else
                begin
                    mirror_entries[mirror_count] = c.item_value;
                    mirror_count++;
                end
            end
            bale_pkg::MODE_INSERT:
            begin
                if (p > mirror_count)
                    r.status = bale_pkg::ST_RANGE;
                else if (mirror_count >= CAP)
                    r.status = bale_pkg::ST_FULL;
                else
                begin
                    for (i = mirror_count; i > p; i--)
                        mirror_entries[i] = mirror_entries[i-1];
                    mirror_entries[p] = c.item_value;
                    mirror_count++;
                end
            end
            bale_pkg::MODE_REMOVE:
            begin
                r.status = live_status(p);
                if (r.status == bale_pkg::ST_OK)
                begin
                    for (i = p; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i+1];
                    mirror_count--;
                end
            end
            bale_pkg::MODE_REPLACE:
            begin
                r.status = live_status(p);
                if (r.status == bale_pkg::ST_OK)
                    mirror_entries[p] = c.item_value;
            end
            bale_pkg::MODE_COMPARE:
            begin
                r.status = live_status(p);
                if (r.status == bale_pkg::ST_OK)
                begin
                    r.read_value = mirror_entries[p];
                    r.match = (mirror_entries[p] == c.item_value);
                end
            end
            bale_pkg::MODE_READ:
            begin
                r.status = live_status(p);
                if (r.status == bale_pkg::ST_OK)
                    r.read_value = mirror_entries[p];
            end
            bale_pkg::MODE_CLEAR:
                mirror_count = 0;
            default:
                ;
        endcase
        r.count = mirror_count[bale_pkg::COUNT_W-1:0];
        r.is_empty = (mirror_count == 0);
        r.is_full = (mirror_count == CAP);
        return r;
    endfunction

    function automatic logic signed [bale_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // bias: 0 balanced, 1 mostly growing, 2 mostly shrinking
    function automatic bale_pkg::cmd_t random_cmd(input int bias);
        bale_pkg::cmd_t c;
        int   roll;
        int   add_w;
        int   rem_w;
        int   n;
        int   p;
        n = mirror_count;
        add_w = (bias == 1) ? 110 : (bias == 2) ? 30 : 60;
        rem_w = (bias == 2) ? 90 : (bias == 1) ? 16 : 40;
        roll = $urandom_range(0, 199);
        c.item_value = pick_value();
        if (roll < add_w)
            c.mode = $urandom_range(0, 1) ? bale_pkg::MODE_APPEND : bale_pkg::MODE_INSERT;
        else if (roll < add_w + rem_w)
            c.mode = bale_pkg::MODE_REMOVE;
        else if (roll < 192)
        begin
            case ($urandom_range(0, 2))
                0: c.mode = bale_pkg::MODE_REPLACE;
                1: c.mode = bale_pkg::MODE_COMPARE;
                default: c.mode = bale_pkg::MODE_READ;
            endcase
        end
        else if (roll < 199)
            c.mode = bale_pkg::MODE_STATUS;
        else
            c.mode = bale_pkg::MODE_CLEAR;

        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 63);
        else if (c.mode == bale_pkg::MODE_INSERT)
            p = $urandom_range(0, (n > 63) ? 63 : n);
        else if (n > 0)
            p = $urandom_range(0, n - 1);
        else
            p = $urandom_range(0, 63);
        c.position = p[bale_pkg::POS_W-1:0];

        if (c.mode == bale_pkg::MODE_COMPARE && p < n && $urandom_range(0, 1))
            c.item_value = mirror_entries[p];
        return c;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic idle_sender(input int cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_cmd(input bale_pkg::cmd_t c);
        cmd <= c;
        cmd_valid <= 1'b1;
        @(negedge clk);
        while (!cmd_ready)
            @(negedge clk);
        @(posedge clk);
        replies_owed.push_back(apply_list_cmd(c));
        if (sender_idles && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 13));
    endtask

    task automatic send_fields(input logic [bale_pkg::MODE_W-1:0] mode, input int p,
                               input logic signed [bale_pkg::VAL_W-1:0] v);
        bale_pkg::cmd_t c;
        c.mode = mode;
        c.position = p[bale_pkg::POS_W-1:0];
        c.item_value = v;
        send_cmd(c);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed.size() != 0);
    endtask

    // Result checking: the transfer happens at the next rising edge.
    always @(negedge clk)
    begin
        bale_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (replies_owed.size() == 0)
                flag_mismatch($sformatf("result with none owed, status %0d count %0d",
                                        rsp.status, rsp.count));
            else
            begin
                want = replies_owed.pop_front();
                if (rsp.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
                if (rsp.match !== want.match)
                    flag_mismatch($sformatf("match %0b, want %0b", rsp.match, want.match));
                if (rsp.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value %0d, want %0d",
                                            rsp.read_value, want.read_value));
                if (rsp.count !== want.count)
                    flag_mismatch($sformatf("count %0d, want %0d", rsp.count, want.count));
                if (rsp.is_empty !== want.is_empty)
                    flag_mismatch($sformatf("is_empty %0b, want %0b",
                                            rsp.is_empty, want.is_empty));
                if (rsp.is_full !== want.is_full)
                    flag_mismatch($sformatf("is_full %0b, want %0b", rsp.is_full, want.is_full));
            end
        end
    end

    // Receiver: random stall bursts plus one long hold on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req != 0)
            begin
                stall_left = long_hold_req;
                long_hold_req = 0;
            end
            else if (stall_left == 0 && receiver_idles && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left != 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bounded_array_list_engine_tb: errors");
        $finish;
    end

    task automatic test_empty_list();
        send_fields(bale_pkg::MODE_STATUS, 63, 32'sh7FFF_FFFF);
        send_fields(bale_pkg::MODE_REMOVE, 0, '0);
        send_fields(bale_pkg::MODE_REPLACE, 63, -32'sd1);
        send_fields(bale_pkg::MODE_COMPARE, 0, '0);
        send_fields(bale_pkg::MODE_READ, 63, 32'sh8000_0000);
        send_fields(bale_pkg::MODE_INSERT, 1, 32'sd5);
        send_fields(bale_pkg::MODE_CLEAR, 42, '0);
    endtask

    task automatic test_each_mode();
        send_fields(bale_pkg::MODE_APPEND, 0, 32'sh8000_0000);
        send_fields(bale_pkg::MODE_APPEND, 21, 32'sh7FFF_FFFF);
        send_fields(bale_pkg::MODE_INSERT, 0, -32'sd1);
        send_fields(bale_pkg::MODE_INSERT, 3, '0);
        send_fields(bale_pkg::MODE_INSERT, 9, 32'sd77);
        send_fields(bale_pkg::MODE_READ, 0, '0);
        send_fields(bale_pkg::MODE_READ, 3, '0);
        send_fields(bale_pkg::MODE_READ, 4, '0);
        send_fields(bale_pkg::MODE_READ, 63, '0);
        send_fields(bale_pkg::MODE_COMPARE, 1, 32'sh8000_0000);
        send_fields(bale_pkg::MODE_COMPARE, 2, 32'sh7FFF_FFFE);
        send_fields(bale_pkg::MODE_REPLACE, 2, 32'sh1234_5678);
        send_fields(bale_pkg::MODE_READ, 2, '0);
        send_fields(bale_pkg::MODE_REMOVE, 0, '0);
        send_fields(bale_pkg::MODE_REMOVE, 2, '0);
        send_fields(bale_pkg::MODE_REMOVE, 5, '0);
        send_fields(bale_pkg::MODE_STATUS, 0, -32'sd1);
        send_fields(bale_pkg::MODE_CLEAR, 0, '0);
        send_fields(bale_pkg::MODE_READ, 0, '0);
    endtask

    // Full-list errors and the longest shifts in both directions.
    task automatic test_full_list();
        while (mirror_count < CAP)
            send_fields(bale_pkg::MODE_APPEND, $urandom_range(0, 63), pick_value());
        send_fields(bale_pkg::MODE_APPEND, 0, 32'sd1);
        send_fields(bale_pkg::MODE_INSERT, 63, 32'sd2);
        send_fields(bale_pkg::MODE_INSERT, 0, 32'sd3);
        send_fields(bale_pkg::MODE_READ, 63, '0);
        send_fields(bale_pkg::MODE_COMPARE, 63, mirror_entries[63]);
        send_fields(bale_pkg::MODE_REMOVE, 0, '0);
        send_fields(bale_pkg::MODE_INSERT, 0, pick_value());
        send_fields(bale_pkg::MODE_REPLACE, 63, pick_value());
        send_fields(bale_pkg::MODE_REMOVE, 63, '0);
        send_fields(bale_pkg::MODE_INSERT, 63, pick_value());
        send_fields(bale_pkg::MODE_STATUS, 63, '0);
    endtask

    task automatic test_backpressure();
        long_hold_req = 300;
        repeat (40) send_cmd(random_cmd(0));
    endtask

    task automatic test_pause_for_drain();
        repeat (15) send_cmd(random_cmd(0));
        wait_drained();
        repeat (15) send_cmd(random_cmd(0));
    endtask

    task automatic test_random_walk();
        int bias;
        repeat (11)
        begin
            bias = $urandom_range(0, 2);
            sender_idles = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
            repeat (100) send_cmd(random_cmd(bias));
        end
    endtask

    task automatic test_full_rate();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (200) send_cmd(random_cmd(0));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_each_mode();
        test_full_list();
        test_backpressure();
        test_pause_for_drain();
        test_random_walk();
        test_full_rate();
        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("bounded_array_list_engine_tb: clean");
        else
            $display("bounded_array_list_engine_tb: errors");
        $finish;
    end

endmodule
